[hw/rtl/crc8cfr_pkg.sv]
// Package: transfer types, status codes and the CRC-8 byte update for the frame receiver.
`timescale 1ns / 1ps

package crc8cfr_pkg;

   localparam int RELAY_COUNT_DEF = 6;
   localparam int RELAY_BITS      = 6;
   localparam int COUNT_BITS      = 4;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [RELAY_BITS-1:0] relay_states;
      logic [15:0]           volume;
   } rsp_type;

   // MSB-first CRC-8 update over one byte, unrolled to eight shift steps.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/crc8cfr_frame_check.sv]
// Frame state: byte count, running CRC, relay and volume capture, and the end-of-frame verdict.
`timescale 1ns / 1ps

module crc8cfr_frame_check #(
   parameter int RELAY_COUNT = crc8cfr_pkg::RELAY_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  crc8cfr_pkg::req_type item,
   output crc8cfr_pkg::rsp_type result
);
   import crc8cfr_pkg::*;

   localparam logic [COUNT_BITS-1:0] FRAME_LEN  = COUNT_BITS'(RELAY_COUNT + 5);
   localparam logic [COUNT_BITS-1:0] VOL_LO_POS = COUNT_BITS'(RELAY_COUNT + 1);
   localparam logic [COUNT_BITS-1:0] VOL_HI_POS = COUNT_BITS'(RELAY_COUNT + 2);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            crc_ff, crc_in;
   logic [RELAY_BITS-1:0] relay_ff, relay_in;
   logic [15:0]           volume_ff, volume_in;

   always_comb begin
      relay_in  = relay_ff;
      volume_in = volume_ff;
      for (int i = 0; i < RELAY_BITS; i++) begin
         if (i < RELAY_COUNT && count_ff == COUNT_BITS'(i + 1)) begin
            relay_in[i] = (item.data_byte != 8'h00);
         end
      end
      if (count_ff == VOL_LO_POS) begin
         volume_in[7:0] = item.data_byte;
      end
      if (count_ff == VOL_HI_POS) begin
         volume_in[15:8] = item.data_byte;
      end
      crc_in   = crc8_next(crc_ff, item.data_byte);
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   // Length is checked before the CRC; captured fields are shown only on success.
   always_comb begin
      result = '0;
      if (count_in != FRAME_LEN) begin
         result.status = STATUS_BAD_LEN;
      end else if (crc_in != 8'h00) begin
         result.status = STATUS_BAD_CRC;
      end else begin
         result.status       = STATUS_OK;
         result.relay_states = relay_in;
         result.volume       = volume_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.frame_end)) begin
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         relay_ff  <= '0;
         volume_ff <= '0;
      end else if (step) begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         relay_ff  <= relay_in;
         volume_ff <= volume_in;
      end
   end

endmodule

[hw/rtl/crc8_checked_control_frame_receiver_top.sv]
// Top level of the CRC-8 checked control frame receiver: input stage, frame check, result register.
`timescale 1ns / 1ps

// A frame's last byte is registered in the input stage and its result in the result register, which
// drives rsp; the result loads once that register is free or its held result is being taken.
// Throughput: one byte per cycle; the input stage and the result register each hold one item,
// so the only stall is a final byte waiting behind an untaken result.
// Reset: synchronous, active high; clears both stages and returns the frame state to count 0,
// CRC 0xFF and cleared captures.
module crc8_checked_control_frame_receiver_top #(
   parameter int RELAY_COUNT = crc8cfr_pkg::RELAY_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  crc8cfr_pkg::req_type req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output crc8cfr_pkg::rsp_type rsp
);
   import crc8cfr_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   logic    in_advance;
   logic    out_load;
   rsp_type check_result;

   // A byte that ends no frame produces no result, so it never waits on the output side.
   assign in_advance = in_valid_ff && (!in_item_ff.frame_end || !out_valid_ff || rsp_ready);
   assign out_load   = in_advance && in_item_ff.frame_end;
   assign req_ready  = !in_valid_ff || in_advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !in_advance);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   crc8cfr_frame_check #(
      .RELAY_COUNT(RELAY_COUNT)
   ) u_frame_check (
      .clock (clock),
      .reset (reset),
      .step  (in_advance),
      .item  (in_item_ff),
      .result(check_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req;
      end
      if (out_load) begin
         out_item_ff <= check_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_item_ff;

   a_reject_clears_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.status != STATUS_OK
         |-> out_item_ff.relay_states == '0 && out_item_ff.volume == '0)
      else $error("rejected frame carries nonzero relay or volume fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_item_ff.status == STATUS_OK || out_item_ff.status == STATUS_BAD_CRC
                       || out_item_ff.status == STATUS_BAD_LEN)
      else $error("result status is not a defined code");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_item_ff.frame_end && out_valid_ff && !rsp_ready)
      else $error("input stalled without a waiting final byte and a held result");

   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !$past(out_valid_ff) |-> $past(out_load))
      else $error("result appeared without a final byte leaving the input stage");

endmodule

[bench/tb.sv]
// Self-checking testbench for the CRC-8 checked control frame receiver.
`timescale 1ns / 1ps

module tb;
   import crc8cfr_pkg::*;

   localparam int RELAYS     = RELAY_COUNT_DEF;
   localparam int FRAME_LEN  = RELAYS + 5;
   localparam int CYCLE_CAP  = 200000;
   localparam int PHASE_BYTES = 200;

   // Frame state tracker and store of expected frame verdicts.
   class frame_scoreboard;
      logic [COUNT_BITS-1:0] byte_count;
      logic [7:0]            crc;
      logic [RELAY_BITS-1:0] relays;
      logic [15:0]           volume;
      rsp_type               pending_results[$];
      int                    errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_count = '0;
         crc        = CRC_INIT;
         relays     = '0;
         volume     = '0;
      endfunction

      // Shifts one byte into the CRC register bit by bit, most significant bit first.
      static function logic [7:0] crc8_shift_in(input logic [7:0] crc_in, input logic [7:0] b);
         logic [7:0] r;
         logic       feedback;
         r = crc_in;
         for (int i = 7; i >= 0; i--) begin
            feedback = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      function void take_byte(input req_type item);
         rsp_type verdict;
         int      pos;
         pos = byte_count;
         if (pos >= 1 && pos <= RELAYS) begin
            relays[pos-1] = (item.data_byte != 8'h00);
         end else if (pos == RELAYS + 1) begin
            volume[7:0] = item.data_byte;
         end else if (pos == RELAYS + 2) begin
            volume[15:8] = item.data_byte;
         end
         crc = crc8_shift_in(crc, item.data_byte);
         if (byte_count != COUNT_MAX) begin
            byte_count = byte_count + 1'b1;
         end
         if (item.frame_end) begin
            verdict = '0;
            if (byte_count != FRAME_LEN) begin
               verdict.status = STATUS_BAD_LEN;
            end else if (crc != 8'h00) begin
               verdict.status = STATUS_BAD_CRC;
            end else begin
               verdict.status       = STATUS_OK;
               verdict.relay_states = relays;
               verdict.volume       = volume;
            end
            pending_results.push_back(verdict);
            clear_frame();
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.relay_states !== want.relay_states) begin
            $display("%0t: relay_states mismatch, expected %h, actual %h",
                     $time, want.relay_states, got.relay_states);
            errors++;
         end
         if (got.volume !== want.volume) begin
            $display("%0t: volume mismatch, expected %h, actual %h",
                     $time, want.volume, got.volume);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   frame_scoreboard sb;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              random_bytes;
   logic [7:0]      frame_bytes[$];

   crc8_checked_control_frame_receiver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.take_byte(req);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{data_byte: b, frame_end: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   // Appending the CRC of the bytes so far leaves a zero remainder over the whole frame.
   task automatic append_crc();
      logic [7:0] c;
      c = CRC_INIT;
      foreach (frame_bytes[i]) begin
         c = frame_scoreboard::crc8_shift_in(c, frame_bytes[i]);
      end
      frame_bytes.push_back(c);
   endtask

   task automatic build_good_frame();
      int vol_pick;
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom));
      for (int i = 0; i < RELAYS; i++) begin
         frame_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      vol_pick = $urandom_range(7);
      if (vol_pick == 0) begin
         frame_bytes.push_back(8'h00);
         frame_bytes.push_back(8'h00);
      end else if (vol_pick == 1) begin
         frame_bytes.push_back(8'hFF);
         frame_bytes.push_back(8'hFF);
      end else begin
         frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(8'($urandom));
      end
      frame_bytes.push_back(8'($urandom));
      append_crc();
   endtask

   task automatic build_random_frame();
      int kind;
      int len;
      int idx;
      kind = $urandom_range(99);
      build_good_frame();
      if (kind < 60) begin
         return;
      end
      if (kind < 75) begin
         // A single flipped bit is always caught by the CRC.
         idx = $urandom_range(FRAME_LEN - 1);
         frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
         return;
      end
      if (kind < 90) begin
         do len = $urandom_range(1, 14); while (len == FRAME_LEN);
      end else if ($urandom_range(2) == 0) begin
         // Sixteen bytes past a valid length would alias if the count wrapped.
         len = FRAME_LEN + 16;
      end else begin
         len = $urandom_range(15, 24);
      end
      frame_bytes.delete();
      for (int i = 0; i < len - 1; i++) begin
         frame_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(1)) begin
         append_crc();
      end else begin
         frame_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int start_count;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_count    = random_bytes;
      while (random_bytes - start_count < PHASE_BYTES) begin
         build_random_frame();
         send_frame();
         random_bytes += frame_bytes.size();
      end
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req            = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_bytes   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Good frame with every relay on and full-scale volume.
      frame_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'hFF, 8'hFF, 8'hFF};
      append_crc();
      send_frame();
      // All-zero payload with a corrupted check byte.
      frame_bytes = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      append_crc();
      frame_bytes[FRAME_LEN-1] = frame_bytes[FRAME_LEN-1] ^ 8'hFF;
      send_frame();
      // A transaction of one byte.
      frame_bytes = '{8'hFF};
      send_frame();

      run_phase(0, 0);
      run_phase(68, 0);
      run_phase(0, 68);
      run_phase(37, 37);
      req_valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[crc8_checked_control_frame_receiver_top.f]
hw/rtl/crc8cfr_pkg.sv
hw/rtl/crc8cfr_frame_check.sv
hw/rtl/crc8_checked_control_frame_receiver_top.sv
bench/tb.sv
